// ===== sv/bsa_pkg.sv =====
package bsa_pkg;

    localparam int SLOTS     = 128;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CAP_W     = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    // word index of the capacity register, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        OP_ALLOCATE = 3'd0,
        OP_FREE     = 3'd1,
        OP_RESERVE  = 3'd2,
        OP_QUERY    = 3'd3,
        OP_READ     = 3'd4,
        OP_WRITE    = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  index_in;
        logic [31:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  slot_index;
        logic [31:0] read_data;
        logic        slot_is_free;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== sv/bitmap_slot_allocator.sv =====
// First-fit slot allocator over 128 slots, each with an occupancy bit and a 32-bit entry.
// One operation is in flight at a time and passes through the idle state that captures
// the input beat, the exec state in which the masked find-first-free encoder over the
// occupancy map and the single entry-RAM port do the work, and the response state that
// shows the result and holds it until the output side takes it; only then can a new
// input beat be accepted. The occupancy map resets to all free, so no clearing pass is
// needed; entry data is undefined until written. Capacity sits at byte address 0 of the
// register port, resets to 128, and values above 128 act as 128; write it only while
// the block is idle.
module bitmap_slot_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  bsa_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bsa_pkg::t_out_item          o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsa_pkg::APB_AW-1:0]  paddr,
    input  logic [bsa_pkg::APB_DW-1:0]  pwdata,
    output logic [bsa_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    bsa_pkg::t_dp_cmd          cmd;
    logic [bsa_pkg::CAP_W-1:0] capacity;

    bsa_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bsa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_capacity (capacity),
        .o_out_item (o_out_item)
    );

endmodule

// ===== sv/bsa_regs.sv =====
module bsa_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsa_pkg::APB_AW-1:0]  paddr,
    input  logic [bsa_pkg::APB_DW-1:0]  pwdata,
    output logic [bsa_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [bsa_pkg::CAP_W-1:0]   o_capacity
);

    logic [bsa_pkg::CAP_W-1:0] r_capacity;
    logic                      wr_cap;

    assign pready = 1'b1;
    assign wr_cap = psel && penable && pwrite && (paddr[2] == bsa_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bsa_pkg::CAP_RESET;
        end else if (wr_cap) begin
            r_capacity <= pwdata[bsa_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bsa_pkg::REG_CAPACITY) begin
            prdata = {{(bsa_pkg::APB_DW - bsa_pkg::CAP_W){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule

// ===== sv/bsa_ctrl.sv =====
module bsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bsa_pkg::t_dp_cmd o_cmd
);

    bsa_pkg::t_state r_state;
    bsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            bsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bsa_pkg::S_EXEC;
                end
            end
            bsa_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = bsa_pkg::S_RESP;
            end
            bsa_pkg::S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bsa_dp.sv =====
module bsa_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bsa_pkg::t_dp_cmd          i_cmd,
    input  bsa_pkg::t_in_item         i_in_item,
    input  logic [bsa_pkg::CAP_W-1:0] i_capacity,
    output bsa_pkg::t_out_item        o_out_item
);

    localparam int IW = bsa_pkg::IDX_W;
    localparam int CW = bsa_pkg::CNT_W;
    localparam int DW = bsa_pkg::DATA_BITS;

    logic [DW-1:0]             mem [bsa_pkg::SLOTS];

    bsa_pkg::t_in_item         r_item;
    logic [bsa_pkg::SLOTS-1:0] r_occ;
    logic [bsa_pkg::SLOTS-1:0] n_occ;
    logic [CW-1:0]             r_hint;
    logic [CW-1:0]             n_hint;
    logic [IW-1:0]             r_slot;
    logic [IW-1:0]             n_slot;
    logic                      r_free;
    logic                      n_free;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      r_rd_sel;
    logic                      n_rd_sel;
    logic [DW-1:0]             r_mem_q;

    logic [CW-1:0]             eff_cap;
    logic [bsa_pkg::SLOTS-1:0] elig;
    logic                      found;
    logic [IW-1:0]             first;
    logic [CW-1:0]             idx_ext;
    logic                      idx_ok;
    logic                      mem_we;
    logic [IW-1:0]             mem_waddr;
    logic                      mem_re;

    // register values above the slot count act as the slot count
    assign eff_cap = ({1'b0, i_capacity} > (bsa_pkg::CAP_W + 1)'(bsa_pkg::SLOTS)) ?
                     CW'(bsa_pkg::SLOTS) : CW'(i_capacity);

    assign idx_ext = {{(CW - IW){1'b0}}, r_item.index_in[IW-1:0]};
    assign idx_ok  = idx_ext < eff_cap;

    // free slots in the window [hint, capacity)
    always_comb begin
        for (int k = 0; k < bsa_pkg::SLOTS; k++) begin
            elig[k] = !r_occ[k] && (CW'(k) >= r_hint) && (CW'(k) < eff_cap);
        end
    end

    assign found = |elig;

    always_comb begin
        first = '0;
        for (int k = bsa_pkg::SLOTS - 1; k >= 0; k--) begin
            if (elig[k]) begin
                first = IW'(k);
            end
        end
    end

    always_comb begin
        n_occ     = r_occ;
        n_hint    = r_hint;
        n_slot    = r_item.index_in[IW-1:0];
        n_free    = 1'b0;
        n_status  = bsa_pkg::ST_OK;
        n_rd_sel  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_item.index_in[IW-1:0];
        mem_re    = 1'b0;
        case (r_item.operation)
            bsa_pkg::OP_ALLOCATE: begin
                if (found) begin
                    n_occ[first] = 1'b1;
                    n_hint       = {{(CW - IW){1'b0}}, first} + CW'(1);
                    n_slot       = first;
                    mem_we       = 1'b1;
                    mem_waddr    = first;
                end else begin
                    if (r_hint < eff_cap) begin
                        n_hint = eff_cap;
                    end
                    n_slot   = '0;
                    n_status = bsa_pkg::ST_FULL;
                end
            end
            bsa_pkg::OP_FREE, bsa_pkg::OP_RESERVE, bsa_pkg::OP_QUERY,
            bsa_pkg::OP_READ, bsa_pkg::OP_WRITE: begin
                if (!idx_ok) begin
                    n_status = bsa_pkg::ST_RANGE;
                end else begin
                    case (r_item.operation)
                        bsa_pkg::OP_FREE: begin
                            n_occ[r_item.index_in[IW-1:0]] = 1'b0;
                            if (r_hint > idx_ext) begin
                                n_hint = idx_ext;
                            end
                        end
                        bsa_pkg::OP_RESERVE: begin
                            n_occ[r_item.index_in[IW-1:0]] = 1'b1;
                            if (r_hint == idx_ext) begin
                                n_hint = r_hint + CW'(1);
                            end
                        end
                        bsa_pkg::OP_QUERY: begin
                            n_free = !r_occ[r_item.index_in[IW-1:0]];
                        end
                        bsa_pkg::OP_READ: begin
                            mem_re   = 1'b1;
                            n_rd_sel = 1'b1;
                        end
                        bsa_pkg::OP_WRITE: begin
                            mem_we = 1'b1;
                        end
                        default: begin
                            n_status = bsa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                // unused codes: echo only
                n_status = bsa_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_hint <= '0;
        end else if (i_cmd.exec) begin
            r_occ  <= n_occ;
            r_hint <= n_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_slot   <= n_slot;
            r_free   <= n_free;
            r_status <= n_status;
            r_rd_sel <= n_rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            mem[mem_waddr] <= r_item.data_in[DW-1:0];
        end
        if (i_cmd.exec && mem_re) begin
            r_mem_q <= mem[r_item.index_in[IW-1:0]];
        end
    end

    always_comb begin
        o_out_item              = '0;
        o_out_item.slot_index   = r_slot;
        o_out_item.read_data    = r_rd_sel ? r_mem_q : '0;
        o_out_item.slot_is_free = r_free;
        o_out_item.status       = r_status;
    end

endmodule

// ===== sv/bsa_checker.sv =====
module bsa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bsa_pkg::t_out_item o_out_item
);

    // result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat dropped or changed while stalled");

    // one operation at a time
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == bsa_pkg::ST_FULL) |-> o_out_item.slot_index == '0)
        else $error("full allocate returned a nonzero slot");

    a_free_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.slot_is_free |-> o_out_item.status == bsa_pkg::ST_OK)
        else $error("free flag with error status");

    // an accepted beat yields a result after the exec state
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("result not presented after accept");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
